@@ rtl/core/spt_pkg.sv @@
package spt_pkg;

  typedef enum logic {
    CMD_QUERY = 1'b0,
    CMD_MOVE  = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_MOTOR_STEPS  = 1'b0,
    CFG_INITIAL_RATE = 1'b1
  } cfg_idx_e;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned DELTA_W     = 23;
  localparam int unsigned QUOT_W      = 23;

  localparam logic [15:0] SPR_RESET = 16'd200;
  localparam logic [15:0] RATE_MIN  = 16'd100;
  localparam logic [15:0] RATE_MAX  = 16'd2000;

  // floor(x/1000) = (x * ceil(2^38/1000)) >> 38 for any 32-bit x
  localparam logic [28:0] RECIP_1000 = 29'd274877907;
  // floor(n/45) = (n * ceil(2^34/45)) >> 34 for any 28-bit n
  localparam logic [28:0] RECIP_45   = 29'd381774871;

  typedef struct packed {
    cmd_e                 cmd;
    logic [DELTA_W-1:0]   delta;
    logic signed [31:0]   steps;
    logic [15:0]          rate;
  } entry_t;

endpackage

@@ rtl/core/spt_front.sv @@
module spt_front #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms [31:0], degrees_q8 [55:32], rate_hz [71:56]
  input  logic [spt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd [0]
  input  logic [0:0]                         s_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic [$clog2(DEPTH+1)-1:0]         fifo_cnt_i,
  output logic                               push_o,
  output spt_pkg::entry_t                    entry_o
);

  localparam int unsigned CW = $clog2(DEPTH + 4);

  logic               in_acc;
  logic [31:0]        now;
  logic signed [23:0] deg;
  logic [15:0]        rate_in;
  logic [15:0]        rate_cl;
  spt_pkg::cmd_e      cmd;
  logic [31:0]        elapsed;
  logic [47:0]        prt;
  logic signed [39:0] pdeg;
  logic [CW-1:0]      in_flight;

  logic [15:0] spr_q, spr_d;
  logic [15:0] rate_q, rate_d;
  logic [31:0] prev_now_q, prev_now_d;

  logic               s1_v_q;
  spt_pkg::cmd_e      s1_cmd_q;
  logic [31:0]        s1_prt_q;
  logic signed [39:0] s1_pdeg_q;
  logic [15:0]        s1_rate_q;

  logic [60:0]        dprod;
  logic [39:0]        mag;

  logic                        s2_v_q;
  spt_pkg::cmd_e               s2_cmd_q;
  logic [spt_pkg::DELTA_W-1:0] s2_delta_q;
  logic [27:0]                 s2_n_q;
  logic                        s2_neg_q;
  logic [15:0]                 s2_rate_q;

  logic [56:0]                 qprod;

  logic                        s3_v_q;
  spt_pkg::cmd_e               s3_cmd_q;
  logic [spt_pkg::DELTA_W-1:0] s3_delta_q;
  logic [spt_pkg::QUOT_W-1:0]  s3_q_q;
  logic                        s3_neg_q;
  logic [15:0]                 s3_rate_q;

  logic [31:0]                 quot32;

  assign now     = s_axis_tdata[31:0];
  assign deg     = $signed(s_axis_tdata[55:32]);
  assign rate_in = s_axis_tdata[71:56];
  assign cmd     = spt_pkg::cmd_e'(s_axis_tuser[0]);

  // credit check: every request in the pipe already owns a queue slot
  assign in_flight = CW'(fifo_cnt_i) + CW'(s1_v_q) + CW'(s2_v_q) + CW'(s3_v_q);
  assign s_axis_tready = in_flight < CW'(DEPTH);
  assign in_acc = s_axis_tvalid & s_axis_tready;

  assign elapsed = now - prev_now_q;
  assign prt     = rate_q * elapsed;
  assign pdeg    = deg * $signed({1'b0, spr_q});

  always_comb begin
    if (rate_in < spt_pkg::RATE_MIN) begin
      rate_cl = spt_pkg::RATE_MIN;
    end else if (rate_in > spt_pkg::RATE_MAX) begin
      rate_cl = spt_pkg::RATE_MAX;
    end else begin
      rate_cl = rate_in;
    end
  end

  always_comb begin
    spr_d      = spr_q;
    rate_d     = rate_q;
    prev_now_d = prev_now_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spt_pkg::CFG_MOTOR_STEPS:  spr_d  = cfg_data_i;
        spt_pkg::CFG_INITIAL_RATE: rate_d = cfg_data_i;
        default: ;
      endcase
    end
    if (in_acc) begin
      prev_now_d = now;
      if (cmd == spt_pkg::CMD_MOVE) begin
        rate_d = rate_cl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q      <= spt_pkg::SPR_RESET;
      rate_q     <= 16'd0;
      prev_now_q <= 32'd0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
    end else begin
      spr_q      <= spr_d;
      rate_q     <= rate_d;
      prev_now_q <= prev_now_d;
      s1_v_q     <= in_acc;
      s2_v_q     <= s1_v_q;
      s3_v_q     <= s2_v_q;
    end
  end

  // stage 1: rate * elapsed and degrees * motor steps
  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= cmd;
    s1_prt_q  <= prt[31:0];
    s1_pdeg_q <= pdeg;
    s1_rate_q <= (cmd == spt_pkg::CMD_MOVE) ? rate_cl : rate_q;
  end

  // stage 2: divide by 1000, take magnitude over 2048 (92160 = 2048 * 45)
  assign dprod = s1_prt_q * spt_pkg::RECIP_1000;
  assign mag   = s1_pdeg_q[39] ? 40'(-s1_pdeg_q) : 40'(s1_pdeg_q);

  always_ff @(posedge clk_i) begin
    s2_cmd_q   <= s1_cmd_q;
    s2_delta_q <= dprod[60:38];
    s2_n_q     <= mag[38:11];
    s2_neg_q   <= s1_pdeg_q[39];
    s2_rate_q  <= s1_rate_q;
  end

  // stage 3: divide magnitude by 45
  assign qprod = s2_n_q * spt_pkg::RECIP_45;

  always_ff @(posedge clk_i) begin
    s3_cmd_q   <= s2_cmd_q;
    s3_delta_q <= s2_delta_q;
    s3_q_q     <= qprod[56:34];
    s3_neg_q   <= s2_neg_q;
    s3_rate_q  <= s2_rate_q;
  end

  assign quot32 = {9'd0, s3_q_q};

  assign push_o        = s3_v_q;
  assign entry_o.cmd   = s3_cmd_q;
  assign entry_o.delta = s3_delta_q;
  assign entry_o.steps = s3_neg_q ? $signed(-quot32) : $signed(quot32);
  assign entry_o.rate  = s3_rate_q;

endmodule

@@ rtl/core/spt_fifo.sv @@
module spt_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  spt_pkg::entry_t             entry_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output spt_pkg::entry_t             entry_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  spt_pkg::entry_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o = mem_q[rd_ptr_q];
  assign valid_o = cnt_q != '0;
  assign count_o = cnt_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < NW'(DEPTH))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("request queue underflow");
`endif

endmodule

@@ rtl/core/spt_back.sv @@
module spt_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  spt_pkg::entry_t                    entry_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // position [31:0], target [63:32], moving [64], forward [65],
  // active_rate_hz [81:66], zero [87:82]
  output logic [spt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic [31:0] est_q, est_d;
  logic [31:0] goal_q, goal_d;
  logic        moving_q, moving_d;
  logic        dir_q, dir_d;
  logic        out_v_q, out_v_d;
  logic [spt_pkg::OUT_TDATA_W-1:0] out_q, out_d;

  logic        pop;
  logic [31:0] delta32;
  logic [31:0] np;
  logic [31:0] adv;
  logic        reached;

  assign pop   = valid_i & (~out_v_q | m_axis_tready);
  assign pop_o = pop;

  assign delta32 = {9'd0, entry_i.delta};
  assign np      = dir_q ? est_q + delta32 : est_q - delta32;
  assign adv     = moving_q ? np : est_q;
  assign reached = dir_q ? ($signed(np) >= $signed(goal_q))
                         : ($signed(np) <= $signed(goal_q));

  always_comb begin
    est_d    = est_q;
    goal_d   = goal_q;
    moving_d = moving_q;
    dir_d    = dir_q;
    if (pop) begin
      unique case (entry_i.cmd)
        spt_pkg::CMD_MOVE: begin
          est_d    = adv;
          goal_d   = adv + entry_i.steps;
          dir_d    = ~entry_i.steps[31];
          moving_d = 1'b1;
        end
        spt_pkg::CMD_QUERY: begin
          if (moving_q) begin
            if (reached) begin
              est_d    = goal_q;
              moving_d = 1'b0;
            end else begin
              est_d = np;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_v_d = out_v_q & ~m_axis_tready;
    out_d   = out_q;
    if (pop) begin
      out_v_d = 1'b1;
      out_d   = {6'd0, entry_i.rate, dir_d, moving_d, goal_d, est_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q    <= 32'd0;
      goal_q   <= 32'd0;
      moving_q <= 1'b0;
      dir_q    <= 1'b1;
      out_v_q  <= 1'b0;
    end else begin
      est_q    <= est_d;
      goal_q   <= goal_d;
      moving_q <= moving_d;
      dir_q    <= dir_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_stop_on_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(moving_q) |-> est_q == goal_q)
    else $error("motion stopped away from target");

  a_stop_by_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(moving_q) |-> $past(pop && entry_i.cmd == spt_pkg::CMD_QUERY))
    else $error("motion stopped without a query");

  a_result_per_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_v_q)
    else $error("popped request produced no result");
`endif

endmodule

@@ rtl/core/stepper_position_tracker.sv @@
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: now_ms, degrees_q8, rate_hz; tuser: cmd
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: position, target, moving, forward, rate
// cfg       in   cfg_we_i (no wait)            cfg_idx_i selects register, cfg_data_i value
//
// one request per cycle sustained while the output is not stalled; each result passes through
// three front stages (rate * elapsed and degrees * motor steps, the /1000 reciprocal,
// the /45 reciprocal of the magnitude over 2048), one queue stage and the output register
// reset clears position, target, motion and time, sets forward, motor steps 200, rate 0
// s_axis_tready drops once queue and front stages hold FIFO_DEPTH requests (output stall)
module stepper_position_tracker #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms [31:0], degrees_q8 [55:32], rate_hz [71:56]
  input  logic [spt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd [0]
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // position [31:0], target [63:32], moving [64], forward [65],
  // active_rate_hz [81:66], zero [87:82]
  output logic [spt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [15:0]                        cfg_data_i
);

  logic                                push;
  spt_pkg::entry_t                     push_entry;
  logic                                pop;
  logic                                q_valid;
  spt_pkg::entry_t                     q_entry;
  logic [$clog2(FIFO_DEPTH+1)-1:0]     q_count;

  spt_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fifo_cnt_i    (q_count),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  spt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .count_o (q_count)
  );

  spt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (q_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
